// ===== hw/rtl/kcs_host_transaction_engine_macros.svh =====
// assertion macros for the kcs host transaction engine
`ifndef KCS_HOST_TRANSACTION_ENGINE_MACROS_SVH
`define KCS_HOST_TRANSACTION_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define KCS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define KCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KCS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define KCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/kcs_pkg.sv =====
// types and constants shared by the kcs host transaction engine
`timescale 1ns / 1ps

package kcs_pkg;

  localparam logic [7:0] CMD_WRITE_START = 8'h61;
  localparam logic [7:0] CMD_WRITE_END   = 8'h62;
  localparam logic [7:0] CMD_READ        = 8'h68;

  localparam int unsigned ST_OBF_BIT = 0;
  localparam int unsigned ST_IBF_BIT = 1;

  localparam logic [1:0] IF_IDLE  = 2'd0;
  localparam logic [1:0] IF_READ  = 2'd1;
  localparam logic [1:0] IF_WRITE = 2'd2;

  localparam logic [1:0] REG_POLL_LIMIT     = 2'd0;
  localparam logic [1:0] REG_RESPONSE_LIMIT = 2'd1;

  localparam logic OP_REQUEST_BYTE = 1'b0;
  localparam logic OP_READ_VALUE   = 1'b1;

  localparam logic [19:0] POLL_LIMIT_RESET     = 20'd200000;
  localparam logic [7:0]  RESPONSE_LIMIT_RESET = 8'd64;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_READ_STATUS = 3'd1,
    ACT_READ_DATA   = 3'd2,
    ACT_WRITE_CMD   = 3'd3,
    ACT_WRITE_DATA  = 3'd4,
    ACT_NEED_BYTE   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TIMEOUT  = 2'd1,
    ERR_PROTOCOL = 2'd2,
    ERR_OVERLEN  = 2'd3
  } error_t;

  typedef enum logic [15:0] {
    PH_IDLE        = 16'h0001,
    PH_START_WAIT  = 16'h0002,
    PH_START_DSTAT = 16'h0004,
    PH_START_DDATA = 16'h0008,
    PH_PUT_WAIT    = 16'h0010,
    PH_PUT_DSTAT   = 16'h0020,
    PH_PUT_DDATA   = 16'h0040,
    PH_END_WAIT    = 16'h0080,
    PH_END_DSTAT   = 16'h0100,
    PH_END_DDATA   = 16'h0200,
    PH_NEED        = 16'h0400,
    PH_RX_WAIT     = 16'h0800,
    PH_RX_OBF_READ = 16'h1000,
    PH_RX_OBF_IDLE = 16'h2000,
    PH_RX_DATA     = 16'h4000,
    PH_RX_FINAL    = 16'h8000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_byte;
    logic        held_is_last;
    logic        held_sent;
    logic [19:0] poll_counter;
    logic [7:0]  received_count;
  } state_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] request_byte;
    logic       is_last;
    logic [7:0] read_value;
  } item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] write_value;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    error_t     error_code;
    logic [7:0] response_count;
  } result_t;

endpackage

// ===== hw/rtl/kcs_step.sv =====
// one sequencer step: next state and result for one input beat
`timescale 1ns / 1ps

module kcs_step (
  input  kcs_pkg::state_t  state,
  input  kcs_pkg::item_t   item,
  input  logic [19:0]      poll_limit,
  input  logic [7:0]       response_limit,
  output kcs_pkg::state_t  state_next,
  output kcs_pkg::result_t result
);

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PUT   = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  logic            ibf;
  logic            obf;
  logic [1:0]      if_state;
  logic            is_read;
  logic            do_poll;
  logic            do_proceed;
  logic            do_send;
  logic            do_finish;
  kind_t           kind;
  kcs_pkg::error_t finish_err;
  kcs_pkg::state_t nx;
  kcs_pkg::result_t r;

  assign ibf      = item.read_value[kcs_pkg::ST_IBF_BIT];
  assign obf      = item.read_value[kcs_pkg::ST_OBF_BIT];
  assign if_state = item.read_value[7:6];
  assign is_read  = (item.operation == kcs_pkg::OP_READ_VALUE);

  always_comb begin
    nx         = state;
    r          = '0;
    do_poll    = 1'b0;
    do_proceed = 1'b0;
    do_send    = 1'b0;
    do_finish  = 1'b0;
    kind       = KIND_START;
    finish_err = kcs_pkg::ERR_NONE;

    case (state.phase)
      kcs_pkg::PH_IDLE: begin
        if (!is_read) begin
          nx.held_byte      = item.request_byte;
          nx.held_is_last   = item.is_last;
          nx.held_sent      = 1'b0;
          nx.received_count = '0;
          nx.poll_counter   = 20'd1;
          nx.phase          = kcs_pkg::PH_START_WAIT;
          r.action          = kcs_pkg::ACT_READ_STATUS;
        end
      end
      kcs_pkg::PH_NEED: begin
        if (!is_read) begin
          nx.held_byte    = item.request_byte;
          nx.held_is_last = item.is_last;
          nx.held_sent    = 1'b0;
          do_send         = 1'b1;
        end
      end
      kcs_pkg::PH_START_WAIT, kcs_pkg::PH_PUT_WAIT, kcs_pkg::PH_END_WAIT: begin
        if (is_read) begin
          if (ibf) begin
            do_poll = 1'b1;
          end else if (state.phase != kcs_pkg::PH_START_WAIT &&
                       if_state != kcs_pkg::IF_WRITE) begin
            do_finish  = 1'b1;
            finish_err = kcs_pkg::ERR_PROTOCOL;
          end else begin
            r.action = kcs_pkg::ACT_READ_STATUS;
            case (state.phase)
              kcs_pkg::PH_START_WAIT: nx.phase = kcs_pkg::PH_START_DSTAT;
              kcs_pkg::PH_PUT_WAIT:   nx.phase = kcs_pkg::PH_PUT_DSTAT;
              default:                nx.phase = kcs_pkg::PH_END_DSTAT;
            endcase
          end
        end
      end
      kcs_pkg::PH_START_DSTAT, kcs_pkg::PH_PUT_DSTAT, kcs_pkg::PH_END_DSTAT: begin
        if (is_read) begin
          case (state.phase)
            kcs_pkg::PH_START_DSTAT: kind = KIND_START;
            kcs_pkg::PH_PUT_DSTAT:   kind = KIND_PUT;
            default:                 kind = KIND_END;
          endcase
          if (obf) begin
            r.action = kcs_pkg::ACT_READ_DATA;
            case (state.phase)
              kcs_pkg::PH_START_DSTAT: nx.phase = kcs_pkg::PH_START_DDATA;
              kcs_pkg::PH_PUT_DSTAT:   nx.phase = kcs_pkg::PH_PUT_DDATA;
              default:                 nx.phase = kcs_pkg::PH_END_DDATA;
            endcase
          end else begin
            do_proceed = 1'b1;
          end
        end
      end
      kcs_pkg::PH_START_DDATA, kcs_pkg::PH_PUT_DDATA, kcs_pkg::PH_END_DDATA: begin
        if (is_read) begin
          do_proceed = 1'b1;
          case (state.phase)
            kcs_pkg::PH_START_DDATA: kind = KIND_START;
            kcs_pkg::PH_PUT_DDATA:   kind = KIND_PUT;
            default:                 kind = KIND_END;
          endcase
        end
      end
      kcs_pkg::PH_RX_WAIT: begin
        if (is_read) begin
          if (ibf) begin
            do_poll = 1'b1;
          end else if (if_state == kcs_pkg::IF_READ) begin
            nx.poll_counter = 20'd1;
            nx.phase        = kcs_pkg::PH_RX_OBF_READ;
            r.action        = kcs_pkg::ACT_READ_STATUS;
          end else if (if_state == kcs_pkg::IF_IDLE) begin
            nx.poll_counter = 20'd1;
            nx.phase        = kcs_pkg::PH_RX_OBF_IDLE;
            r.action        = kcs_pkg::ACT_READ_STATUS;
          end else begin
            do_finish  = 1'b1;
            finish_err = kcs_pkg::ERR_PROTOCOL;
          end
        end
      end
      kcs_pkg::PH_RX_OBF_READ: begin
        if (is_read) begin
          if (!obf) begin
            do_poll = 1'b1;
          end else if (state.received_count >= response_limit) begin
            do_finish  = 1'b1;
            finish_err = kcs_pkg::ERR_OVERLEN;
          end else begin
            r.action = kcs_pkg::ACT_READ_DATA;
            nx.phase = kcs_pkg::PH_RX_DATA;
          end
        end
      end
      kcs_pkg::PH_RX_OBF_IDLE: begin
        if (is_read) begin
          if (!obf) begin
            do_poll = 1'b1;
          end else begin
            r.action = kcs_pkg::ACT_READ_DATA;
            nx.phase = kcs_pkg::PH_RX_FINAL;
          end
        end
      end
      kcs_pkg::PH_RX_DATA: begin
        if (is_read) begin
          r.rx_valid        = 1'b1;
          r.rx_byte         = item.read_value;
          nx.received_count = state.received_count + 8'd1;
          r.action          = kcs_pkg::ACT_WRITE_DATA;
          r.write_value     = kcs_pkg::CMD_READ;
          nx.poll_counter   = 20'd1;
          nx.phase          = kcs_pkg::PH_RX_WAIT;
        end
      end
      kcs_pkg::PH_RX_FINAL: begin
        if (is_read) begin
          do_finish  = 1'b1;
          finish_err = kcs_pkg::ERR_NONE;
        end
      end
      default: begin
        nx = state;
      end
    endcase

    // previous start, put or end step finished, move to the next write
    if (do_proceed) begin
      case (kind)
        KIND_START: begin
          nx.held_sent    = 1'b0;
          r.action        = kcs_pkg::ACT_WRITE_CMD;
          r.write_value   = kcs_pkg::CMD_WRITE_START;
          nx.poll_counter = 20'd1;
          nx.phase        = kcs_pkg::PH_PUT_WAIT;
        end
        KIND_PUT: begin
          do_send = 1'b1;
        end
        default: begin
          nx.held_sent    = 1'b1;
          r.action        = kcs_pkg::ACT_WRITE_DATA;
          r.write_value   = state.held_byte;
          nx.poll_counter = 20'd1;
          nx.phase        = kcs_pkg::PH_RX_WAIT;
        end
      endcase
    end

    if (do_send) begin
      if (nx.held_sent) begin
        r.action = kcs_pkg::ACT_NEED_BYTE;
        nx.phase = kcs_pkg::PH_NEED;
      end else if (nx.held_is_last) begin
        r.action        = kcs_pkg::ACT_WRITE_CMD;
        r.write_value   = kcs_pkg::CMD_WRITE_END;
        nx.poll_counter = 20'd1;
        nx.phase        = kcs_pkg::PH_END_WAIT;
      end else begin
        nx.held_sent    = 1'b1;
        r.action        = kcs_pkg::ACT_WRITE_DATA;
        r.write_value   = nx.held_byte;
        nx.poll_counter = 20'd1;
        nx.phase        = kcs_pkg::PH_PUT_WAIT;
      end
    end

    if (do_poll) begin
      if (state.poll_counter >= poll_limit) begin
        do_finish  = 1'b1;
        finish_err = kcs_pkg::ERR_TIMEOUT;
      end else begin
        nx.poll_counter = state.poll_counter + 20'd1;
        r.action        = kcs_pkg::ACT_READ_STATUS;
      end
    end

    if (do_finish) begin
      r.action        = kcs_pkg::ACT_NONE;
      r.done_res      = 1'b1;
      r.error_code    = finish_err;
      nx.phase        = kcs_pkg::PH_IDLE;
      nx.poll_counter = '0;
    end

    r.response_count = nx.received_count;
  end

  assign state_next = nx;
  assign result     = r;

endmodule

// ===== hw/rtl/kcs_host_transaction_engine.sv =====
// top level of the kcs host transaction engine
//
//  channel   direction  beat contents
//  s_axis    in         tuser operation, tlast is_last, tdata request_byte / read_value
//  m_axis    out        tuser action, tlast done_res, tdata write_value .. response_count
//  cfg       in         cfg_index register, cfg_data value (poll_limit, response_limit)
//
// one input beat gives one output beat; the sequencer step is combinational, so a beat
// can be taken every cycle while s_axis_tready is high.
// the result goes to an output register backed by one skid stage; s_axis_tready
// drops only while the skid stage holds a beat.
// rst returns the sequencer to idle and the limits to 200000 and 64.
// cfg_ready is always high.
`timescale 1ns / 1ps
`include "kcs_host_transaction_engine_macros.svh"

module kcs_host_transaction_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // request_byte, read_value
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // write_value, rx_valid, rx_byte, error_code,
                                     // response_count, zero pad
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser,  // action
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  kcs_pkg::state_t  state;
  kcs_pkg::state_t  state_next;
  kcs_pkg::item_t   item;
  kcs_pkg::result_t result;
  kcs_pkg::result_t out_res;
  kcs_pkg::result_t skid_res;
  logic             out_valid;
  logic             skid_valid;
  logic             accept;
  logic [19:0]      poll_limit;
  logic [7:0]       response_limit;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign item.operation    = s_axis_tuser;
  assign item.request_byte = s_axis_tdata[7:0];
  assign item.is_last      = s_axis_tlast;
  assign item.read_value   = s_axis_tdata[15:8];

  kcs_step u_step (
    .state          (state),
    .item           (item),
    .poll_limit     (poll_limit),
    .response_limit (response_limit),
    .state_next     (state_next),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit     <= kcs_pkg::POLL_LIMIT_RESET;
      response_limit <= kcs_pkg::RESPONSE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kcs_pkg::REG_POLL_LIMIT:     poll_limit     <= cfg_data;
        kcs_pkg::REG_RESPONSE_LIMIT: response_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= kcs_pkg::PH_IDLE;
      state.held_byte      <= '0;
      state.held_is_last   <= 1'b0;
      state.held_sent      <= 1'b0;
      state.poll_counter   <= '0;
      state.received_count <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= result;
      end
    end else if (accept) begin
      skid_res <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.done_res;
  assign m_axis_tuser  = out_res.action;
  assign m_axis_tdata  = {5'd0, out_res.response_count, out_res.error_code,
                          out_res.rx_byte, out_res.rx_valid, out_res.write_value};

  `KCS_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid,
    "skid stage holds a beat while the output register is empty")
  `KCS_ASSERT_IMPLY(a_idle_no_poll, clk, rst, state.phase == kcs_pkg::PH_IDLE,
    state.poll_counter == 20'd0, "poll counter left running in idle")
  `KCS_ASSERT_IMPLY(a_done_no_action, clk, rst, out_valid && out_res.done_res,
    out_res.action == kcs_pkg::ACT_NONE, "bus action requested at transaction end")
  `KCS_ASSERT_IMPLY(a_err_only_done, clk, rst, out_valid && !out_res.done_res,
    out_res.error_code == kcs_pkg::ERR_NONE, "error code set before the end")
  `KCS_ASSERT_NEXT(a_finish_to_idle, clk, rst, accept && result.done_res,
    state.phase == kcs_pkg::PH_IDLE, "sequencer not idle after transaction end")

endmodule
